// ===== hdl/delta_r_nearest_match_macros.svh =====
// Assertion macros shared by the delta-R matcher RTL.
`ifndef DELTA_R_NEAREST_MATCH_MACROS_SVH
`define DELTA_R_NEAREST_MATCH_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge out of reset.
`define DRNM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drnm assertion failed");
// Next-cycle implication, checked at every clock edge out of reset.
`define DRNM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drnm assertion failed");
`else
`define DRNM_ASSERT_NOW(label, ante, cons)
`define DRNM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/drnm_pkg.sv =====
// Types and constants shared by the delta-R matcher modules.
package drnm_pkg;

	localparam int MAX_CANDIDATES = 64;
	localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

	localparam int ETA_W  = 16;
	localparam int PHI_W  = 15;
	localparam int THR_W  = 33;
	localparam int MIDX_W = 6;

	// pi and 2*pi at 4096 counts per radian
	localparam logic [PHI_W-1:0] PI_FX     = 15'd12868;
	localparam logic [15:0]      TWO_PI_FX = 16'd25736;

	// Delta-R of 0.4, squared, in counts squared
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 33'd2684355;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_SINGLE = 2'd2;
	localparam logic [1:0] MODE_PAIR   = 2'd3;

	// Control tag that travels with one candidate through the distance unit
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} drnm_tag_t;

endpackage

// ===== hdl/drnm_dist.sv =====
// Squared delta-R unit: one candidate in per cycle; registers difference, square, sum.
module drnm_dist (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  drnm_pkg::drnm_tag_t                    tag_in,
	input  logic signed [drnm_pkg::ETA_W-1:0]      ref_eta,
	input  logic signed [drnm_pkg::PHI_W-1:0]      ref_phi,
	input  logic signed [drnm_pkg::ETA_W-1:0]      cand_eta,
	input  logic signed [drnm_pkg::PHI_W-1:0]      cand_phi,
	output drnm_pkg::drnm_tag_t                    tag_out,
	output logic [drnm_pkg::THR_W-1:0]             dist_sq,
	output logic                                   busy
);
	import drnm_pkg::*;

	logic signed [ETA_W:0]  deta;
	logic signed [15:0]     dphi;
	logic [PHI_W-1:0]       aphi;
	logic signed [15:0]     wphi;
	logic signed [33:0]     prod_e;
	logic signed [31:0]     prod_p;

	drnm_tag_t              tag_s2, tag_s3, tag_s4;
	logic signed [ETA_W:0]  deta_s2;
	logic signed [15:0]     dphi_s2;
	logic [31:0]            sq_e_s3;
	logic [27:0]            sq_p_s3;
	logic [THR_W-1:0]       dist_s4;

	// Differences, with phi folded back across pi
	always_comb begin
		deta = {ref_eta[ETA_W-1], ref_eta} - {cand_eta[ETA_W-1], cand_eta};
		dphi = {ref_phi[PHI_W-1], ref_phi} - {cand_phi[PHI_W-1], cand_phi};
		aphi = dphi[15] ? PHI_W'(-dphi) : dphi[PHI_W-1:0];
		if (aphi >= PI_FX) begin
			wphi = signed'(TWO_PI_FX - {1'b0, aphi});
		end else begin
			wphi = signed'({1'b0, aphi});
		end
	end

	// Squares of both differences
	always_comb begin
		prod_e = deta_s2 * deta_s2;
		prod_p = dphi_s2 * dphi_s2;
	end

	// Advance the tag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Advance the data pipeline
	always_ff @(posedge clk) begin
		deta_s2 <= deta;
		dphi_s2 <= wphi;
		sq_e_s3 <= prod_e[31:0];
		sq_p_s3 <= prod_p[27:0];
		dist_s4 <= THR_W'(sq_e_s3) + THR_W'(sq_p_s3);
	end

	assign tag_out = tag_s4;
	assign dist_sq = dist_s4;
	assign busy    = tag_s2.vld | tag_s3.vld | tag_s4.vld;

endmodule

// ===== hdl/delta_r_nearest_match.sv =====
// Delta-R nearest match: candidate table, scan sequencer and result register.
//
//   channel  direction  handshake                payload
//   input    in         in_valid / in_stall      mode, first_*, second_*
//   result   out        out_valid / out_stall    matched, match_index, status
//   config   in         cfg_wr_en                cfg_wr_data (threshold_sq)
//
// Clear and append load the result register one cycle after the accepting edge.
// A single query loads it after one pass over the table, a pair query after two passes:
// the one distance unit sees one table entry per cycle.
// The next beat is taken the cycle after the result register loads.
// Reset empties the table at once; entries are never cleared, only the count.
// A stalled result holds; one more item is taken meanwhile and waits when it finishes.
`include "delta_r_nearest_match_macros.svh"
module delta_r_nearest_match (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             mode,
	input  logic signed [drnm_pkg::ETA_W-1:0]      first_eta,
	input  logic signed [drnm_pkg::PHI_W-1:0]      first_phi,
	input  logic                                   first_valid,
	input  logic signed [drnm_pkg::ETA_W-1:0]      second_eta,
	input  logic signed [drnm_pkg::PHI_W-1:0]      second_phi,
	input  logic                                   second_valid,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   matched,
	output logic [drnm_pkg::MIDX_W-1:0]            match_index,
	output logic                                   status,
	input  logic                                   cfg_wr_en,
	input  logic [drnm_pkg::THR_W-1:0]             cfg_wr_data
);
	import drnm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam int ENTRY_W = ETA_W + PHI_W;

	logic [1:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        issue_q;
	logic                    pass_q;
	logic [THR_W-1:0]        thr_q;

	logic [1:0]              mode_q;
	logic signed [ETA_W-1:0] e1_q, e2_q;
	logic signed [PHI_W-1:0] p1_q, p2_q;
	logic                    v1_q, v2_q;

	logic [ENTRY_W-1:0]      cand_mem [MAX_CANDIDATES];
	logic [ENTRY_W-1:0]      rd_s1;
	drnm_tag_t               tag_s1;

	logic                    found_q;
	logic [THR_W-1:0]        best_q;
	logic [IDX_W-1:0]        best_pos_q;
	logic                    hit_a_q;
	logic [IDX_W-1:0]        pos_a_q;

	logic                    res_matched_q;
	logic [MIDX_W-1:0]       res_idx_q;
	logic                    res_status_q;

	logic                    out_valid_q;
	logic                    matched_q;
	logic [MIDX_W-1:0]       match_index_q;
	logic                    status_q;

	logic                    accept;
	logic                    issue;
	logic                    pass_end;
	logic                    hit;
	logic                    out_free;
	logic                    cnt_full;
	logic                    pair_hit;

	drnm_tag_t               tag_rd;
	drnm_tag_t               tag_d;
	logic [THR_W-1:0]        dist_d;
	logic                    unit_busy;
	logic signed [ETA_W-1:0] ref_eta;
	logic signed [PHI_W-1:0] ref_phi;

	// Handshake and sequencing conditions
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cnt_full = (cnt_q >= CNT_W'(MAX_CANDIDATES));
	assign issue    = (state_q == ST_SCAN) && (issue_q < cnt_q);
	assign pass_end = (state_q == ST_SCAN) && !issue && !tag_s1.vld && !unit_busy;
	assign hit      = found_q && (best_q <= thr_q);
	assign pair_hit = v1_q && v2_q && hit_a_q && hit && (pos_a_q == best_pos_q);
	assign out_free = !out_valid_q || !out_stall;

	assign tag_rd.vld = issue;
	assign tag_rd.idx = issue_q[IDX_W-1:0];

	// Select the reference for the current pass
	assign ref_eta = pass_q ? e2_q : e1_q;
	assign ref_phi = pass_q ? p2_q : p1_q;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// Candidate table: append writes, scan reads one entry per cycle
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_APPEND) && !cnt_full) begin
			cand_mem[cnt_q[IDX_W-1:0]] <= {first_eta, first_phi};
		end
		rd_s1 <= cand_mem[issue_q[IDX_W-1:0]];
	end

	// Read tag lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_rd;
		end
	end

	drnm_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_s1),
		.ref_eta  (ref_eta),
		.ref_phi  (ref_phi),
		.cand_eta (rd_s1[ENTRY_W-1:PHI_W]),
		.cand_phi (rd_s1[PHI_W-1:0]),
		.tag_out  (tag_d),
		.dist_sq  (dist_d),
		.busy     (unit_busy)
	);

	// Latch the item's references
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			e1_q   <= first_eta;
			p1_q   <= first_phi;
			v1_q   <= first_valid;
			e2_q   <= second_eta;
			p2_q   <= second_phi;
			v2_q   <= second_valid;
		end
	end

	// Keep the running minimum; the earliest entry wins ties
	always_ff @(posedge clk) begin
		if (tag_d.vld && (!found_q || (dist_d < best_q))) begin
			best_q     <= dist_d;
			best_pos_q <= tag_d.idx;
		end
		if (pass_end && (mode_q == MODE_PAIR) && !pass_q) begin
			hit_a_q <= hit;
			pos_a_q <= best_pos_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			issue_q       <= '0;
			pass_q        <= 1'b0;
			found_q       <= 1'b0;
			res_matched_q <= 1'b0;
			res_idx_q     <= '0;
			res_status_q  <= 1'b0;
		end else begin
			if (tag_d.vld) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_matched_q <= 1'b0;
						res_idx_q     <= '0;
						res_status_q  <= 1'b0;
						unique case (mode)
							MODE_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_DONE;
							end
							MODE_APPEND: begin
								if (cnt_full) begin
									res_status_q <= 1'b1;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
								state_q <= ST_DONE;
							end
							MODE_SINGLE, MODE_PAIR: begin
								issue_q <= '0;
								pass_q  <= 1'b0;
								found_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						issue_q <= issue_q + 1'b1;
					end
					if (pass_end) begin
						if ((mode_q == MODE_PAIR) && !pass_q) begin
							// start the second reference over the same table
							pass_q  <= 1'b1;
							issue_q <= '0;
							found_q <= 1'b0;
						end else if (mode_q == MODE_PAIR) begin
							res_matched_q <= pair_hit;
							res_idx_q     <= pair_hit ? MIDX_W'(best_pos_q) : '0;
							state_q       <= ST_DONE;
						end else begin
							res_matched_q <= v1_q && hit;
							res_idx_q     <= (v1_q && hit) ? MIDX_W'(best_pos_q) : '0;
							state_q       <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register: load when free, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			matched_q     <= res_matched_q;
			match_index_q <= res_idx_q;
			status_q      <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign matched     = matched_q;
	assign match_index = match_index_q;
	assign status      = status_q;

	// Checks
	`DRNM_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(MAX_CANDIDATES))
	`DRNM_ASSERT_NOW(a_scan_only, tag_s1.vld || unit_busy, state_q == ST_SCAN)
	`DRNM_ASSERT_NOW(a_unmatched_zero, out_valid_q && !matched_q, match_index_q == '0)
	`DRNM_ASSERT_NOW(a_status_no_match, out_valid_q && status_q, !matched_q)
	`DRNM_ASSERT_NEXT(a_done_loads, (state_q == ST_DONE) && out_free, out_valid_q)

endmodule

// ===== dv/delta_r_nearest_match_check.sv =====
// Result checker for the delta-R matcher: mirrors the candidate table and compares every result beat.
module delta_r_nearest_match_check (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic [1:0]                             mode,
	input  logic signed [drnm_pkg::ETA_W-1:0]      first_eta,
	input  logic signed [drnm_pkg::PHI_W-1:0]      first_phi,
	input  logic                                   first_valid,
	input  logic signed [drnm_pkg::ETA_W-1:0]      second_eta,
	input  logic signed [drnm_pkg::PHI_W-1:0]      second_phi,
	input  logic                                   second_valid,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic                                   matched,
	input  logic [drnm_pkg::MIDX_W-1:0]            match_index,
	input  logic                                   status,
	input  logic                                   cfg_wr_en,
	input  logic [drnm_pkg::THR_W-1:0]             cfg_wr_data,
	output int                                     fail_count,
	output int                                     pending
);
	import drnm_pkg::*;

	typedef struct packed {
		logic              matched;
		logic [MIDX_W-1:0] index;
		logic              status;
	} match_beat_t;

	match_beat_t             match_q[$];
	match_beat_t             oldest;
	logic signed [ETA_W-1:0] cand_eta [MAX_CANDIDATES];
	logic signed [PHI_W-1:0] cand_phi [MAX_CANDIDATES];
	int unsigned             cand_count;
	logic [THR_W-1:0]        limit_sq;

	// Squared angular distance with phi folded at pi; the folded value may go negative
	function automatic longint delta_r_sq(input logic signed [ETA_W-1:0] eta_a,
			input logic signed [PHI_W-1:0] phi_a, input logic signed [ETA_W-1:0] eta_b,
			input logic signed [PHI_W-1:0] phi_b);
		longint de;
		longint dp;
		de = longint'(eta_a) - longint'(eta_b);
		dp = longint'(phi_a) - longint'(phi_b);
		if (dp < 0) dp = -dp;
		if (dp >= longint'(PI_FX)) dp = longint'(TWO_PI_FX) - dp;
		return de * de + dp * dp;
	endfunction

	// Scan the table in order; the earliest candidate wins a tie
	function automatic bit nearest_hit(input logic signed [ETA_W-1:0] eta,
			input logic signed [PHI_W-1:0] phi, output int unsigned pos);
		longint      best;
		longint      dr_sq;
		bit          found;
		int unsigned i;
		found = 1'b0;
		best = 0;
		pos = 0;
		for (i = 0; i < cand_count; i++) begin
			dr_sq = delta_r_sq(eta, phi, cand_eta[i], cand_phi[i]);
			if (!found || dr_sq < best) begin
				found = 1'b1;
				best = dr_sq;
				pos = i;
			end
		end
		return found && best <= longint'(limit_sq);
	endfunction

	// Apply one input beat to the table and return the result it must produce
	function automatic match_beat_t predict_match(input logic [1:0] m,
			input logic signed [ETA_W-1:0] e1, input logic signed [PHI_W-1:0] p1, input logic v1,
			input logic signed [ETA_W-1:0] e2, input logic signed [PHI_W-1:0] p2, input logic v2);
		match_beat_t r;
		int unsigned pa;
		int unsigned pb;
		r = '0;
		pa = 0;
		pb = 0;
		case (m)
			MODE_CLEAR: begin
				cand_count = 0;
			end
			MODE_APPEND: begin
				if (cand_count < MAX_CANDIDATES) begin
					cand_eta[cand_count] = e1;
					cand_phi[cand_count] = p1;
					cand_count++;
				end else begin
					r.status = 1'b1;
				end
			end
			MODE_SINGLE: begin
				if (v1 && nearest_hit(e1, p1, pa)) begin
					r.matched = 1'b1;
					r.index = MIDX_W'(pa);
				end
			end
			MODE_PAIR: begin
				if (v1 && v2 && nearest_hit(e1, p1, pa) && nearest_hit(e2, p2, pb)
						&& pa == pb) begin
					r.matched = 1'b1;
					r.index = MIDX_W'(pa);
				end
			end
		endcase
		return r;
	endfunction

	// Compare result beats first, then queue the prediction for an accepted input beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q.delete();
			cand_count = 0;
			limit_sq = THRESHOLD_RESET;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (match_q.size() == 0) begin
					$error("result beat arrived with no input beat outstanding");
					fail_count++;
				end else begin
					oldest = match_q.pop_front();
					if (matched !== oldest.matched) begin
						$error("matched: expected %0d, got %0d", oldest.matched, matched);
						fail_count++;
					end
					if (match_index !== oldest.index) begin
						$error("match_index: expected %0d, got %0d", oldest.index, match_index);
						fail_count++;
					end
					if (status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, status);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				match_q.insert(match_q.size(), predict_match(mode, first_eta, first_phi,
					first_valid, second_eta, second_phi, second_valid));
			if (cfg_wr_en)
				limit_sq = cfg_wr_data;
			pending <= match_q.size();
		end
	end

endmodule

// ===== dv/delta_r_nearest_match_test.sv =====
// Testbench top for the delta-R matcher: clock, reset, stimulus, back-pressure and verdict.
module delta_r_nearest_match_test;
	import drnm_pkg::*;

	localparam int ITEM_TARGET = 1550;
	localparam int DIRECTED    = 22;
	localparam int PHASES      = 6;
	localparam int PER_PHASE   = (ITEM_TARGET - DIRECTED) / PHASES;
	localparam int LONG_HOLD   = 300;
	localparam int END_WAIT    = 200;

	localparam logic signed [ETA_W-1:0] ETA_MAX = 16'sh7FFF;
	localparam logic signed [ETA_W-1:0] ETA_MIN = 16'sh8000;
	localparam logic signed [PHI_W-1:0] PHI_HI  = 15'sd12868;
	localparam logic signed [PHI_W-1:0] PHI_LO  = -15'sd12868;
	localparam logic signed [PHI_W-1:0] PHI_TOP = 15'sh3FFF;
	localparam logic signed [PHI_W-1:0] PHI_BOT = 15'sh4000;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              mode;
	logic signed [ETA_W-1:0] first_eta;
	logic signed [PHI_W-1:0] first_phi;
	logic                    first_valid;
	logic signed [ETA_W-1:0] second_eta;
	logic signed [PHI_W-1:0] second_phi;
	logic                    second_valid;
	logic                    out_valid;
	logic                    out_stall;
	logic                    matched;
	logic [MIDX_W-1:0]       match_index;
	logic                    status;
	logic                    cfg_wr_en;
	logic [THR_W-1:0]        cfg_wr_data;

	int fail_count;
	int pending;
	int sent = 0;
	int send_idle_pct = 20;
	int stall_idle_pct = 20;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;

	// Stimulus copy of the stored points, used to aim queries and to pick duplicates
	logic signed [ETA_W-1:0] pts_eta [MAX_CANDIDATES];
	logic signed [PHI_W-1:0] pts_phi [MAX_CANDIDATES];
	int unsigned             pts_n = 0;

	delta_r_nearest_match i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.first_eta    (first_eta),
		.first_phi    (first_phi),
		.first_valid  (first_valid),
		.second_eta   (second_eta),
		.second_phi   (second_phi),
		.second_valid (second_valid),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.matched      (matched),
		.match_index  (match_index),
		.status       (status),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	delta_r_nearest_match_check i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.first_eta    (first_eta),
		.first_phi    (first_phi),
		.first_valid  (first_valid),
		.second_eta   (second_eta),
		.second_phi   (second_phi),
		.second_valid (second_valid),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.matched      (matched),
		.match_index  (match_index),
		.status       (status),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bail out if the run hangs
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Drive result back-pressure: random bursts, plus one long hold on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < stall_idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one input beat, maybe after an idle burst, and hold it until accepted
	task automatic send_beat(input logic [1:0] m,
			input logic signed [ETA_W-1:0] e1, input logic signed [PHI_W-1:0] p1, input logic v1,
			input logic signed [ETA_W-1:0] e2, input logic signed [PHI_W-1:0] p2, input logic v2);
		if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		first_eta <= e1;
		first_phi <= p1;
		first_valid <= v1;
		second_eta <= e2;
		second_phi <= p2;
		second_valid <= v2;
		do @(posedge clk); while (in_stall);
		sent++;
		if (m == MODE_CLEAR) begin
			pts_n = 0;
		end else if (m == MODE_APPEND && pts_n < MAX_CANDIDATES) begin
			pts_eta[pts_n] = e1;
			pts_phi[pts_n] = p1;
			pts_n++;
		end
	endtask

	// Stop offering and wait until every result beat has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Any eta; phi mostly within [-pi, pi], now and then anywhere in the field
	function automatic void random_point(output logic signed [ETA_W-1:0] eta,
			output logic signed [PHI_W-1:0] phi);
		int t;
		eta = ETA_W'($urandom_range(0, 65535));
		if ($urandom_range(0, 31) == 0) begin
			phi = PHI_W'($urandom_range(0, 32767));
		end else begin
			t = $urandom_range(0, 25736) - 12868;
			phi = PHI_W'(t);
		end
	endfunction

	// A point on or around stored point k, phi wrapped back into range
	function automatic void point_near(input int unsigned k,
			output logic signed [ETA_W-1:0] eta, output logic signed [PHI_W-1:0] phi);
		int te;
		int tp;
		te = int'(pts_eta[k]);
		tp = int'(pts_phi[k]);
		if ($urandom_range(0, 3) != 0) begin
			te = te + $urandom_range(0, 4000) - 2000;
			tp = tp + $urandom_range(0, 4000) - 2000;
		end
		if (te > 32767) te = 32767;
		if (te < -32768) te = -32768;
		if (tp > 12868) tp = tp - 25736;
		else if (tp < -12868) tp = tp + 25736;
		eta = ETA_W'(te);
		phi = PHI_W'(tp);
	endfunction

	function automatic void query_point(output logic signed [ETA_W-1:0] eta,
			output logic signed [PHI_W-1:0] phi, output int unsigned k);
		k = 0;
		if (pts_n > 0 && $urandom_range(0, 4) != 0) begin
			k = $urandom_range(0, pts_n - 1);
			point_near(k, eta, phi);
		end else begin
			random_point(eta, phi);
		end
	endfunction

	task automatic send_query(input bit pair);
		logic signed [ETA_W-1:0] e1;
		logic signed [PHI_W-1:0] p1;
		logic signed [ETA_W-1:0] e2;
		logic signed [PHI_W-1:0] p2;
		int unsigned             k;
		int unsigned             k2;
		query_point(e1, p1, k);
		// Aim the second reference mostly at the same stored point
		if (pair && pts_n > 0 && $urandom_range(0, 4) < 3) point_near(k, e2, p2);
		else query_point(e2, p2, k2);
		send_beat(pair ? MODE_PAIR : MODE_SINGLE, e1, p1, $urandom_range(0, 15) != 0,
			e2, p2, $urandom_range(0, 15) != 0);
	endtask

	task automatic send_noise();
		logic signed [ETA_W-1:0] e1;
		logic signed [PHI_W-1:0] p1;
		logic signed [ETA_W-1:0] e2;
		logic signed [PHI_W-1:0] p2;
		random_point(e1, p1);
		random_point(e2, p2);
		send_beat(2'($urandom_range(0, 3)), e1, p1, 1'($urandom_range(0, 1)),
			e2, p2, 1'($urandom_range(0, 1)));
	endtask

	// Clear, fill (sometimes past full, sometimes with duplicates), then query
	task automatic run_episode();
		logic signed [ETA_W-1:0] e1;
		logic signed [PHI_W-1:0] p1;
		logic signed [ETA_W-1:0] e2;
		logic signed [PHI_W-1:0] p2;
		int                      n_app;
		int                      n_q;
		int unsigned             k;
		random_point(e1, p1);
		random_point(e2, p2);
		send_beat(MODE_CLEAR, e1, p1, 1'($urandom_range(0, 1)), e2, p2, 1'($urandom_range(0, 1)));
		n_app = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 16);
		repeat (n_app) begin
			if (pts_n > 0 && $urandom_range(0, 7) == 0) begin
				k = $urandom_range(0, pts_n - 1);
				e1 = pts_eta[k];
				p1 = pts_phi[k];
			end else begin
				random_point(e1, p1);
			end
			random_point(e2, p2);
			send_beat(MODE_APPEND, e1, p1, 1'($urandom_range(0, 1)),
				e2, p2, 1'($urandom_range(0, 1)));
		end
		n_q = $urandom_range(4, 24);
		repeat (n_q) begin
			case ($urandom_range(0, 9))
				0: send_noise();
				1, 2, 3, 4: send_query(1'b0);
				default: send_query(1'b1);
			endcase
		end
	endtask

	initial begin
		logic [THR_W-1:0] limits [PHASES];
		int               send_pct [PHASES];
		int               stall_pct [PHASES];
		bit               held;
		bit               paused;
		limits = '{THRESHOLD_RESET, '0, '1, 33'd10737418, THR_W'($urandom_range(100000, 50000000)),
			THRESHOLD_RESET};
		send_pct = '{25, 0, 40, 15, 30, 0};
		stall_pct = '{20, 30, 0, 40, 15, 0};
		held = 1'b0;
		paused = 1'b0;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_CLEAR;
		first_eta <= '0;
		first_phi <= '0;
		first_valid <= 1'b0;
		second_eta <= '0;
		second_phi <= '0;
		second_valid <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table, then four fixed points: two at the eta extremes (phi at -pi and pi), two at the origin
		send_beat(MODE_SINGLE, '0, '0, 1'b1, '0, '0, 1'b1);
		send_beat(MODE_PAIR, '0, '0, 1'b1, '0, '0, 1'b1);
		send_beat(MODE_APPEND, ETA_MIN, PHI_LO, 1'b0, ETA_MAX, PHI_TOP, 1'b0);
		send_beat(MODE_APPEND, ETA_MAX, PHI_HI, 1'b1, ETA_MIN, PHI_BOT, 1'b1);
		send_beat(MODE_APPEND, '0, '0, 1'b0, '0, '0, 1'b0);
		send_beat(MODE_APPEND, '0, '0, 1'b1, '1, '1, 1'b1);
		// Tie goes to the earlier entry; an invalid reference never matches
		send_beat(MODE_SINGLE, '0, '0, 1'b1, '0, '0, 1'b0);
		send_beat(MODE_SINGLE, '0, '0, 1'b0, '0, '0, 1'b1);
		// Phi wraps across pi in both directions
		send_beat(MODE_SINGLE, ETA_MAX, PHI_LO, 1'b1, '0, '0, 1'b0);
		send_beat(MODE_SINGLE, ETA_MIN, PHI_HI, 1'b1, '0, '0, 1'b0);
		// Pair: agreeing, one side invalid, disagreeing, both unmatched
		send_beat(MODE_PAIR, '0, 15'sd10, 1'b1, '0, -15'sd10, 1'b1);
		send_beat(MODE_PAIR, '0, 15'sd10, 1'b1, '0, -15'sd10, 1'b0);
		send_beat(MODE_PAIR, '0, 15'sd10, 1'b0, '0, -15'sd10, 1'b1);
		send_beat(MODE_PAIR, ETA_MIN, PHI_LO, 1'b1, ETA_MAX, PHI_HI, 1'b1);
		send_beat(MODE_PAIR, 16'sd16384, 15'sd6000, 1'b1, -16'sd16384, -15'sd6000, 1'b1);
		// Phi beyond pi: the folded difference goes negative
		send_beat(MODE_APPEND, 16'sd100, PHI_TOP, 1'b1, '0, '0, 1'b1);
		send_beat(MODE_SINGLE, 16'sd100, PHI_BOT, 1'b1, '0, '0, 1'b1);
		send_beat(MODE_SINGLE, 16'sd100, PHI_TOP, 1'b1, '0, '0, 1'b1);
		send_beat(MODE_SINGLE, '1, 15'sd1, 1'b1, '0, '0, 1'b1);
		// Clear, then query the empty table
		send_beat(MODE_CLEAR, ETA_MAX, PHI_TOP, 1'b1, ETA_MAX, PHI_TOP, 1'b1);
		send_beat(MODE_SINGLE, '0, '0, 1'b1, '0, '0, 1'b1);
		send_beat(MODE_PAIR, '0, '0, 1'b1, '0, '0, 1'b1);

		// Random episodes, one threshold per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) write_threshold(limits[ph]);
			send_idle_pct = send_pct[ph];
			stall_idle_pct = stall_pct[ph];
			quiet = (ph == PHASES - 1);
			while (sent < DIRECTED + (ph + 1) * PER_PHASE) begin
				run_episode();
				if (ph == 1 && !held) begin
					hold_request = 1'b1;
					held = 1'b1;
				end
				if (ph == 2 && !paused) begin
					drain_results();
					paused = 1'b1;
				end
			end
		end

		drain_results();
		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
